FILE: design/mgt_pkg.sv
// ----------------------------------------------------------------------------
// mgt_pkg: shared types and constants for the max gap tracker
// Status codes and the record passed from one cell to the next.
// ----------------------------------------------------------------------------
package mgt_pkg;

	localparam int unsigned POS_W  = 32;
	localparam int unsigned STAT_W = 2;

	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_RANGE     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// record handed from a cell to its right neighbor
	typedef struct packed {
		pos_t value;
		logic valid;
		logic lt;
		pos_t runmax;
	} mgt_link_t;

	// broadcast to every cell
	typedef struct packed {
		pos_t pos;
		logic insert;
		pos_t street_length;
	} mgt_ctrl_t;

endpackage

FILE: design/mgt_cell.sv
// ----------------------------------------------------------------------------
// mgt_cell: one slot of the sorted point chain
// Holds one point, compares it against the broadcast position, shifts right
// on insertion and folds its own gap into the running maximum.
// ----------------------------------------------------------------------------
module mgt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mgt_pkg::mgt_ctrl_t ctrl,
	input  mgt_pkg::mgt_link_t left,
	input  logic              right_valid,
	output mgt_pkg::mgt_link_t link,
	output logic              eq
);
	import mgt_pkg::*;

	pos_t value_q;
	logic valid_q;
	logic lt_q;
	logic eq_q;
	pos_t gap_q;
	pos_t runmax_q;
	pos_t gap_left;
	pos_t gap_end;

	always_comb begin
		gap_left = valid_q ? (value_q - left.value) : '0;
		if (valid_q && !right_valid && (ctrl.street_length > value_q)) begin
			gap_end = ctrl.street_length - value_q;
		end else begin
			gap_end = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			lt_q     <= 1'b0;
			eq_q     <= 1'b0;
			gap_q    <= '0;
			runmax_q <= '0;
		end else begin
			lt_q     <= valid_q && (value_q < ctrl.pos);
			eq_q     <= valid_q && (value_q == ctrl.pos);
			gap_q    <= (gap_left > gap_end) ? gap_left : gap_end;
			runmax_q <= (left.runmax > gap_q) ? left.runmax : gap_q;
			if (ctrl.insert && !lt_q) begin
				valid_q <= left.valid;
			end
		end
	end

	// shift right on insertion, the first cell not below pos takes pos
	always_ff @(posedge clk) begin
		if (ctrl.insert && !lt_q) begin
			value_q <= left.lt ? ctrl.pos : left.value;
		end
	end

	assign link.value  = value_q;
	assign link.valid  = valid_q;
	assign link.lt     = lt_q;
	assign link.runmax = runmax_q;
	assign eq          = eq_q;

endmodule

FILE: design/max_gap_tracker.sv
// ----------------------------------------------------------------------------
// max_gap_tracker: largest gap after point insertions
// Keeps inserted positions sorted in a chain of cells and reports the
// largest distance between neighbors, counting 0 and street_length as ends.
// ----------------------------------------------------------------------------
//  channel        dir  payload
//  s_*            in   position
//  m_*            out  largest_gap, status
//  street_length  in   segment length, write enable + data
//
//  each item passes S_CMP, which compares, and S_UPD, which shifts the chain;
//  then in S_SCAN the running maximum ripples through the MAX_POINTS cells,
//  one cell per cycle, before S_OUT hands the result on.
//  reset empties the chain and sets street_length to 1.
//  a result waits in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module max_gap_tracker #(
	parameter int unsigned MAX_POINTS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,   // [31:0] position
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,   // [31:0] largest_gap, [33:32] status
	input  logic                street_length_we,
	input  mgt_pkg::pos_t       street_length_wdata
);
	import mgt_pkg::*;

	localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int unsigned SCAN_W = $clog2(MAX_POINTS + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CMP  = 5'b00010,
		S_UPD  = 5'b00100,
		S_SCAN = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t            state_q;
	pos_t              street_length_q;
	pos_t              pos_q;
	logic              range_bad_q;
	status_t           status_q;
	status_t           status_new;
	logic [CNT_W-1:0]  count_q;
	logic [SCAN_W-1:0] scan_q;
	logic              out_valid_q;
	pos_t              out_gap_q;
	status_t           out_status_q;
	mgt_ctrl_t         ctrl;
	mgt_link_t         links [0:MAX_POINTS];
	logic [MAX_POINTS-1:0] eq_vec;
	logic [MAX_POINTS:0]   valid_vec;
	logic              dup;
	logic              full;
	logic              do_insert;
	pos_t              end_gap;
	pos_t              final_gap;
	logic              out_free;

	assign links[0] = '{value: '0, valid: 1'b1, lt: 1'b1, runmax: '0};
	assign valid_vec[MAX_POINTS] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
			assign valid_vec[gi] = links[gi+1].valid;
			mgt_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.left        (links[gi]),
				.right_valid (valid_vec[gi+1]),
				.link        (links[gi+1]),
				.eq          (eq_vec[gi])
			);
		end
	endgenerate

	assign dup  = |eq_vec;
	assign full = (count_q == CNT_W'(MAX_POINTS));

	always_comb begin
		priority if (range_bad_q) begin
			status_new = ST_RANGE;
		end else if (dup) begin
			status_new = ST_DUPLICATE;
		end else if (full) begin
			status_new = ST_FULL;
		end else begin
			status_new = ST_INSERTED;
		end
	end

	assign do_insert          = (state_q == S_UPD) && (status_new == ST_INSERTED);
	assign ctrl.pos           = pos_q;
	assign ctrl.insert        = do_insert;
	assign ctrl.street_length = street_length_q;

	assign end_gap   = (count_q == '0) ? street_length_q : '0;
	assign final_gap = (links[MAX_POINTS].runmax > end_gap) ? links[MAX_POINTS].runmax : end_gap;
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			street_length_q <= 32'd1;
		end else if (street_length_we) begin
			street_length_q <= street_length_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (do_insert) begin
						count_q <= count_q + 1'b1;
					end
					scan_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == SCAN_W'(MAX_POINTS)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pos_q       <= s_tdata;
			range_bad_q <= (s_tdata == '0) || (s_tdata >= street_length_q);
		end
		if (state_q == S_UPD) begin
			status_q <= status_new;
		end
		if ((state_q == S_OUT) && out_free) begin
			out_gap_q    <= final_gap;
			out_status_q <= status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_status_q, out_gap_q};

endmodule
